>>> hw/rtl/percent_name_encoder_assert.svh
// Assertion macros shared by the encoder RTL.
// Clock and reset are the module ports clock and reset.
`ifndef PERCENT_NAME_ENCODER_ASSERT_SVH
`define PERCENT_NAME_ENCODER_ASSERT_SVH

// Same-cycle implication.
`define PNE_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PNE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/pne_pkg.sv
`timescale 1ns / 1ps

package pne_pkg;

   localparam int unsigned MAX_NAME_BYTES_DEFAULT = 255;

   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_NUL     = 8'h00;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_TOO_LONG = 2'd1,
      ST_DOTS     = 2'd2,
      ST_BAD_BYTE = 2'd3
   } status_type;

   // Which character of an escape sequence goes out next.
   typedef enum logic [1:0] {
      PH_PCT = 2'd0,
      PH_HI  = 2'd1,
      PH_LO  = 2'd2
   } phase_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] ch;
      if (nib < 4'd10) begin
         ch = 8'h30 + {4'd0, nib};
      end else begin
         ch = 8'h37 + {4'd0, nib};
      end
      return ch;
   endfunction

   // Letters, digits, dot, underscore, hyphen.
   function automatic logic is_safe(input logic [7:0] b);
      return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
             (b >= 8'h30 && b <= 8'h39) || b == CHAR_DOT || b == 8'h5F ||
             b == 8'h2D;
   endfunction

endpackage

>>> hw/rtl/percent_name_encoder.sv
`timescale 1ns / 1ps
// percent_name_encoder
// Percent-encodes a filename streamed one raw byte per request on req_*.
// req_tlast marks the final byte of a name. Safe bytes (letters, digits,
// '.', '_', '-') come out unchanged as one character on rsp_*; any other
// byte comes out as '%' and two uppercase hex digits, one character a
// cycle while rsp_tready is high. rsp_tuser[0] flags the last character
// of each input byte, rsp_tlast the last character of the name, and
// rsp_tuser[2:1] then carries the status (ok, too long, "." or "..",
// slash or NUL). Characters are emitted even for a bad name; the
// receiver drops names whose status is not ok. The byte of a request is
// registered in the holding register, each character then in the result
// register; a safe byte gives one character, an escaped byte three.
// A one-entry holding register sits in front of the result register, so a
// new request is taken in the cycle the previous one issues its last char.
// When a held result sees rsp_tready low, the result register and holding register freeze
// and req_tready drops once the holding register is occupied.
// Reset (synchronous, active high) empties both registers and restarts the
// name state: zero byte count, dots-only set, no bad byte seen.
`include "percent_name_encoder_assert.svh"

module percent_name_encoder
   import pne_pkg::*;
#(
   parameter int unsigned MAX_NAME_BYTES = MAX_NAME_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,  // [7:0] raw_byte
   input  logic       req_tlast,  // name_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,  // [7:0] out_char
   output logic       rsp_tlast,  // name_end
   output logic [2:0] rsp_tuser   // [0] run_last, [2:1] status
);

   // Count saturates at MAX_NAME_BYTES + 1.
   localparam int unsigned CountWidth = $clog2(MAX_NAME_BYTES + 2);
   localparam logic [CountWidth-1:0] CountMax = CountWidth'(MAX_NAME_BYTES);

   // Per-name running state.
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  only_dots_ff, only_dots_in;
   logic                  bad_seen_ff, bad_seen_in;

   // Holding register: byte being expanded.
   logic       hold_valid_ff, hold_valid_in;
   logic [7:0] hold_byte_ff;
   logic       hold_last_ff;
   logic       hold_safe_ff;
   status_type hold_status_ff;
   phase_type  hold_phase_ff, hold_phase_in;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_char_ff;
   logic       rsp_run_last_ff;
   logic       rsp_name_end_ff;
   status_type rsp_status_ff;

   logic                  req_fire;
   logic                  out_load;
   logic                  hold_final;
   logic [7:0]            char_sel;
   logic [CountWidth-1:0] count_next;
   logic                  only_dots_next;
   logic                  bad_seen_next;
   status_type            status_next;

   assign out_load   = hold_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign hold_final = hold_safe_ff || (hold_phase_ff == PH_LO);
   assign req_tready = !hold_valid_ff || (out_load && hold_final);
   assign req_fire   = req_tvalid && req_tready;

   // Name state as updated by the incoming byte.
   always_comb begin
      count_next     = (count_ff <= CountMax) ? count_ff + CountWidth'(1) : count_ff;
      only_dots_next = only_dots_ff && (req_tdata == CHAR_DOT);
      bad_seen_next  = bad_seen_ff || (req_tdata == CHAR_SLASH) ||
                       (req_tdata == CHAR_NUL);
      if (count_next > CountMax) begin
         status_next = ST_TOO_LONG;
      end else if (only_dots_next && count_next <= CountWidth'(2)) begin
         status_next = ST_DOTS;
      end else if (bad_seen_next) begin
         status_next = ST_BAD_BYTE;
      end else begin
         status_next = ST_OK;
      end
   end

   // Next state of the name counters, holding register and result valid.
   always_comb begin
      count_in      = count_ff;
      only_dots_in  = only_dots_ff;
      bad_seen_in   = bad_seen_ff;
      hold_valid_in = hold_valid_ff;
      hold_phase_in = hold_phase_ff;
      rsp_valid_in  = rsp_valid_ff;

      case (hold_phase_ff)
         PH_PCT:  char_sel = hold_safe_ff ? hold_byte_ff : CHAR_PERCENT;
         PH_HI:   char_sel = hex_char(hold_byte_ff[7:4]);
         PH_LO:   char_sel = hex_char(hold_byte_ff[3:0]);
         default: char_sel = CHAR_PERCENT;
      endcase

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
         if (hold_final) begin
            hold_valid_in = 1'b0;
         end else if (hold_phase_ff == PH_PCT) begin
            hold_phase_in = PH_HI;
         end else begin
            hold_phase_in = PH_LO;
         end
      end

      if (req_fire) begin
         hold_valid_in = 1'b1;
         hold_phase_in = PH_PCT;
         if (req_tlast) begin
            count_in     = '0;
            only_dots_in = 1'b1;
            bad_seen_in  = 1'b0;
         end else begin
            count_in     = count_next;
            only_dots_in = only_dots_next;
            bad_seen_in  = bad_seen_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         only_dots_ff  <= 1'b1;
         bad_seen_ff   <= 1'b0;
         hold_valid_ff <= 1'b0;
         hold_phase_ff <= PH_PCT;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         only_dots_ff  <= only_dots_in;
         bad_seen_ff   <= bad_seen_in;
         hold_valid_ff <= hold_valid_in;
         hold_phase_ff <= hold_phase_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers, no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         hold_byte_ff   <= req_tdata;
         hold_last_ff   <= req_tlast;
         hold_safe_ff   <= is_safe(req_tdata);
         hold_status_ff <= req_tlast ? status_next : ST_OK;
      end
      if (out_load) begin
         rsp_char_ff     <= char_sel;
         rsp_run_last_ff <= hold_final;
         rsp_name_end_ff <= hold_final && hold_last_ff;
         rsp_status_ff   <= (hold_final && hold_last_ff) ? hold_status_ff : ST_OK;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_name_end_ff;
   assign rsp_tuser  = {rsp_status_ff, rsp_run_last_ff};

   // A stalled result freezes the escape sequence in progress.
   `PNE_ASSERT_NEXT(a_stall_holds_phase,
      hold_valid_ff && rsp_valid_ff && !rsp_tready,
      hold_valid_ff && $stable(hold_phase_ff),
      "escape phase moved while result stalled")

   // A new request only replaces a byte that issues its last character now.
   `PNE_ASSERT_NOW(a_no_overwrite,
      req_tready && hold_valid_ff,
      out_load && hold_final,
      "holding register overwritten")

   // Status is only reported on the final character of a name.
   `PNE_ASSERT_NOW(a_status_at_end,
      rsp_valid_ff && !rsp_name_end_ff,
      rsp_status_ff == ST_OK,
      "status set away from name end")

   // The end of a name is also the end of its byte's characters.
   `PNE_ASSERT_NOW(a_end_is_run_last,
      rsp_valid_ff && rsp_name_end_ff,
      rsp_run_last_ff,
      "name end without run end")

endmodule
